### rtl/ntms_pkg.sv
package ntms_pkg;

   localparam int NTMS_MAX_NODES = 64;
   localparam int NODE_ID_W = 6;
   localparam int SET_W = 64;
   localparam int SET_LOG2 = $clog2(SET_W);
   localparam int TIME_W = 32;
   localparam int AGE_W = 8;
   localparam int COUNT_W = SET_LOG2 + 1;

   localparam logic [AGE_W-1:0] MAX_AGE_RESET = AGE_W'(3);

   localparam logic [1:0] OP_HELLO = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_PICK = 2'd2;
   localparam logic [1:0] OP_QUERY = 2'd3;

   // One table entry as it leaves the memory, already stripped of covered ids.
   typedef struct packed {
      logic vld;
      logic [NODE_ID_W-1:0] idx;
      logic [SET_W-1:0] set;
   } ntms_cand_type;

   // Best entry found so far in the current selection round.
   typedef struct packed {
      logic [COUNT_W-1:0] cnt;
      logic [NODE_ID_W-1:0] idx;
      logic [SET_W-1:0] set;
   } ntms_best_type;

   // Adder tree population count, one level of independent adds per pass.
   function automatic logic [COUNT_W-1:0] ntms_popcount(input logic [SET_W-1:0] v);
      logic [COUNT_W-1:0] sum [SET_W];
      int lvl;
      int k;
      for (k = 0; k < SET_W; k++) begin
         sum[k] = COUNT_W'(v[k]);
      end
      for (lvl = 1; lvl <= SET_LOG2; lvl++) begin
         for (k = 0; k < (SET_W >> lvl); k++) begin
            sum[k] = sum[2*k] + sum[2*k+1];
         end
      end
      return sum[0];
   endfunction

endpackage

### rtl/ntms_relay_pick.sv
module ntms_relay_pick
   import ntms_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic clear,
   input  ntms_cand_type cand,
   output ntms_best_type best
);

   logic s1_vld_ff;
   logic s1_vld_in;
   logic [COUNT_W-1:0] s1_cnt_ff;
   logic [COUNT_W-1:0] s1_cnt_in;
   logic [NODE_ID_W-1:0] s1_idx_ff;
   logic [SET_W-1:0] s1_set_ff;
   ntms_best_type best_ff;
   ntms_best_type best_in;

   assign s1_vld_in = cand.vld && !clear;
   assign s1_cnt_in = ntms_popcount(cand.set);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_cnt_ff <= s1_cnt_in;
      s1_idx_ff <= cand.idx;
      s1_set_ff <= cand.set;
   end

   // Entries arrive in ascending id order, so a strict compare keeps the
   // lowest id among equal counts.
   always_comb begin
      best_in = best_ff;
      priority if (clear) begin
         best_in = '0;
      end else if (s1_vld_ff && (s1_cnt_ff > best_ff.cnt)) begin
         best_in.cnt = s1_cnt_ff;
         best_in.idx = s1_idx_ff;
         best_in.set = s1_set_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         best_ff <= '0;
      end else begin
         best_ff <= best_in;
      end
   end

   assign best = best_ff;

endmodule

### rtl/neighbor_table_mpr_select.sv
// Neighbor table with greedy relay selection. Pulse start with busy low to
// hand in one command beat; its result appears on the rsp_ ports for exactly
// one cycle with rsp_strobe high and must be taken then, since the receiver
// cannot stall it. A hello or a query reads one entry, then writes or returns
// it before the result beat. A tick walks the table once to drop aged entries,
// and a relay computation that selects R relays walks it R + 1 times. Both walk
// the table through its single memory read port one entry per cycle, and the
// relay computation makes one such walk per selection round through a shared
// population count and compare unit. The csr port writes max_age and must be
// used only while the block is idle.
module neighbor_table_mpr_select
   import ntms_pkg::*;
#(
   parameter int MAX_NODES = NTMS_MAX_NODES
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  logic [1:0] req_op,
   input  logic [NODE_ID_W-1:0] req_originator,
   input  logic [SET_W-1:0] req_neighbor_set,
   output logic rsp_strobe,
   output logic [SET_W-1:0] rsp_one_hop_set,
   output logic [SET_W-1:0] rsp_relay_set,
   output logic [SET_W-1:0] rsp_node_neighbors,
   output logic rsp_table_changed,
   input  logic csr_wr_en,
   input  logic [AGE_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CNT_W = $clog2(MAX_NODES + 2);
   localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(MAX_NODES - 1);
   localparam logic [CNT_W-1:0] TICK_END = CNT_W'(MAX_NODES);
   localparam logic [CNT_W-1:0] PICK_END = CNT_W'(MAX_NODES + 1);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_HELLO_RD = 4'd1;
   localparam logic [3:0] S_HELLO_WR = 4'd2;
   localparam logic [3:0] S_QUERY_RD = 4'd3;
   localparam logic [3:0] S_QUERY_GET = 4'd4;
   localparam logic [3:0] S_TICK = 4'd5;
   localparam logic [3:0] S_PICK = 4'd6;
   localparam logic [3:0] S_PICK_END = 4'd7;
   localparam logic [3:0] S_FIN = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NODE_ID_W-1:0] id_ff, id_in;
   logic [SET_W-1:0] set_ff, set_in;
   logic [MAX_NODES-1:0] valid_ff, valid_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic changed_ff, changed_in;
   logic [AGE_W-1:0] max_age_ff;
   logic [SET_W-1:0] covered_ff, covered_in;
   logic [SET_W-1:0] relay_ff, relay_in;
   logic [SET_W-1:0] node_nb_ff, node_nb_in;

   logic rsp_strobe_ff, rsp_strobe_in;
   logic [SET_W-1:0] rsp_one_hop_ff, rsp_one_hop_in;
   logic [SET_W-1:0] rsp_relay_ff, rsp_relay_in;
   logic [SET_W-1:0] rsp_node_ff, rsp_node_in;
   logic rsp_changed_ff, rsp_changed_in;

   logic [SET_W-1:0] nb_mem [MAX_NODES];
   logic [TIME_W-1:0] hd_mem [MAX_NODES];
   logic [SET_W-1:0] nb_q_ff;
   logic [TIME_W-1:0] hd_q_ff;
   logic [IDX_W-1:0] rd_idx_ff;
   logic rd_vld_ff;

   logic rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic wr_nb_en;
   logic wr_hd_en;
   logic [IDX_W-1:0] id_idx;
   logic id_ok;
   logic [TIME_W-1:0] age;
   logic pick_clear;
   ntms_cand_type cand;
   ntms_best_type best;

   assign id_idx = id_ff[IDX_W-1:0];
   assign id_ok = ({1'b0, id_ff} < (NODE_ID_W + 1)'(MAX_NODES));
   assign age = now_ff - hd_q_ff;
   assign busy = (state_ff != S_IDLE);

   assign cand.vld = rd_vld_ff && (state_ff == S_PICK) && valid_ff[rd_idx_ff];
   assign cand.idx = NODE_ID_W'(rd_idx_ff);
   assign cand.set = nb_q_ff & ~covered_ff;

   ntms_relay_pick u_pick (
      .clock (clock),
      .reset (reset),
      .clear (pick_clear),
      .cand  (cand),
      .best  (best)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      id_in = id_ff;
      set_in = set_ff;
      valid_in = valid_ff;
      now_in = now_ff;
      changed_in = changed_ff;
      covered_in = covered_ff;
      relay_in = relay_ff;
      node_nb_in = node_nb_ff;
      rsp_strobe_in = 1'b0;
      rsp_one_hop_in = rsp_one_hop_ff;
      rsp_relay_in = rsp_relay_ff;
      rsp_node_in = rsp_node_ff;
      rsp_changed_in = rsp_changed_ff;
      rd_en = 1'b0;
      rd_addr = cnt_ff[IDX_W-1:0];
      wr_nb_en = 1'b0;
      wr_hd_en = 1'b0;
      pick_clear = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               id_in = req_originator;
               set_in = req_neighbor_set;
               cnt_in = '0;
               relay_in = '0;
               node_nb_in = '0;
               unique case (req_op)
                  OP_HELLO: begin
                     state_in = S_HELLO_RD;
                  end
                  OP_TICK: begin
                     now_in = now_ff + TIME_W'(1);
                     state_in = S_TICK;
                  end
                  OP_PICK: begin
                     changed_in = 1'b0;
                     covered_in = SET_W'(valid_ff);
                     pick_clear = 1'b1;
                     state_in = S_PICK;
                  end
                  OP_QUERY: begin
                     state_in = S_QUERY_RD;
                  end
               endcase
            end
         end
         S_HELLO_RD: begin
            rd_en = 1'b1;
            rd_addr = id_idx;
            state_in = S_HELLO_WR;
         end
         S_HELLO_WR: begin
            // An identical set from a live entry only refreshes its time.
            if (id_ok) begin
               wr_hd_en = 1'b1;
               if (!(valid_ff[id_idx] && (nb_q_ff == set_ff))) begin
                  wr_nb_en = 1'b1;
                  valid_in[id_idx] = 1'b1;
                  changed_in = 1'b1;
               end
            end
            state_in = S_FIN;
         end
         S_QUERY_RD: begin
            rd_en = 1'b1;
            rd_addr = id_idx;
            state_in = S_QUERY_GET;
         end
         S_QUERY_GET: begin
            if (id_ok && valid_ff[id_idx]) begin
               node_nb_in = nb_q_ff;
            end
            state_in = S_FIN;
         end
         S_TICK: begin
            rd_en = (cnt_ff <= SCAN_LAST);
            if (rd_vld_ff && valid_ff[rd_idx_ff] && (age > TIME_W'(max_age_ff))) begin
               valid_in[rd_idx_ff] = 1'b0;
               changed_in = 1'b1;
            end
            if (cnt_ff == TICK_END) begin
               state_in = S_FIN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_PICK: begin
            // The memory read register and the count stage register trail the last address.
            rd_en = (cnt_ff <= SCAN_LAST);
            if (cnt_ff == PICK_END) begin
               state_in = S_PICK_END;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         S_PICK_END: begin
            cnt_in = '0;
            if (best.cnt == '0) begin
               state_in = S_FIN;
            end else begin
               relay_in = relay_ff | (SET_W'(1) << best.idx);
               covered_in = covered_ff | best.set;
               pick_clear = 1'b1;
               state_in = S_PICK;
            end
         end
         S_FIN: begin
            rsp_strobe_in = 1'b1;
            rsp_one_hop_in = SET_W'(valid_ff);
            rsp_relay_in = relay_ff;
            rsp_node_in = node_nb_ff;
            rsp_changed_in = changed_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         now_ff <= '0;
         changed_ff <= 1'b0;
         max_age_ff <= MAX_AGE_RESET;
         rsp_strobe_ff <= 1'b0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         now_ff <= now_in;
         changed_ff <= changed_in;
         if (csr_wr_en) begin
            max_age_ff <= csr_wr_data;
         end
         rsp_strobe_ff <= rsp_strobe_in;
         rd_vld_ff <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      id_ff <= id_in;
      set_ff <= set_in;
      covered_ff <= covered_in;
      relay_ff <= relay_in;
      node_nb_ff <= node_nb_in;
      rsp_one_hop_ff <= rsp_one_hop_in;
      rsp_relay_ff <= rsp_relay_in;
      rsp_node_ff <= rsp_node_in;
      rsp_changed_ff <= rsp_changed_in;
   end

   always_ff @(posedge clock) begin
      if (wr_nb_en) begin
         nb_mem[id_idx] <= set_ff;
      end
      if (wr_hd_en) begin
         hd_mem[id_idx] <= now_ff;
      end
      if (rd_en) begin
         nb_q_ff <= nb_mem[rd_addr];
         hd_q_ff <= hd_mem[rd_addr];
      end
      rd_idx_ff <= rd_addr;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_one_hop_set = rsp_one_hop_ff;
   assign rsp_relay_set = rsp_relay_ff;
   assign rsp_node_neighbors = rsp_node_ff;
   assign rsp_table_changed = rsp_changed_ff;

endmodule

### rtl/ntms_checker.sv
module ntms_checker
   import ntms_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic [SET_W-1:0] rsp_one_hop_set,
   input logic [SET_W-1:0] rsp_relay_set,
   input logic [SET_W-1:0] rsp_node_neighbors
);

   // An accepted command beat always makes the block busy.
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy did not rise after an accepted beat");

   // A result beat closes a command, so the block was busy just before it.
   a_strobe_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) && !busy))
      else $error("result beat without a preceding busy command");

   // Result beats are single cycle pulses.
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // Relays and a queried neighbor set never come from the same command.
   a_exclusive_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_relay_set != '0)) |-> (rsp_node_neighbors == '0))
      else $error("relay set and queried neighbors both nonzero");

   // Relays are chosen only among valid one hop neighbors.
   a_relay_subset: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_relay_set & ~rsp_one_hop_set) == '0))
      else $error("relay outside the one hop set");

endmodule

bind neighbor_table_mpr_select ntms_checker u_ntms_checker (.*);

### tb/testbench.sv
module testbench;
   import ntms_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES = NTMS_MAX_NODES + 16;

   typedef enum logic {
      CMD_BEAT,
      CMD_AGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0] op;
      logic [NODE_ID_W-1:0] node;
      logic [SET_W-1:0] nset;
      logic [AGE_W-1:0] age;
   } nt_cmd_type;

   typedef struct packed {
      logic [SET_W-1:0] one_hop_set;
      logic [SET_W-1:0] relay_set;
      logic [SET_W-1:0] node_neighbors;
      logic table_changed;
   } nt_reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_op = OP_HELLO;
   logic [NODE_ID_W-1:0] req_originator = '0;
   logic [SET_W-1:0] req_neighbor_set = '0;
   logic rsp_strobe;
   logic [SET_W-1:0] rsp_one_hop_set;
   logic [SET_W-1:0] rsp_relay_set;
   logic [SET_W-1:0] rsp_node_neighbors;
   logic rsp_table_changed;
   logic csr_wr_en = 1'b0;
   logic [AGE_W-1:0] csr_wr_data = '0;

   neighbor_table_mpr_select u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_originator(req_originator),
      .req_neighbor_set(req_neighbor_set),
      .rsp_strobe(rsp_strobe),
      .rsp_one_hop_set(rsp_one_hop_set),
      .rsp_relay_set(rsp_relay_set),
      .rsp_node_neighbors(rsp_node_neighbors),
      .rsp_table_changed(rsp_table_changed),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of the neighbor table.
   logic [NTMS_MAX_NODES-1:0] node_valid;
   logic [SET_W-1:0] node_nbrs [NTMS_MAX_NODES];
   logic [TIME_W-1:0] node_heard [NTMS_MAX_NODES];
   logic [TIME_W-1:0] now_sec;
   logic dirty;
   logic [AGE_W-1:0] age_limit;

   nt_cmd_type cmd_queue [$];
   nt_reply_type expected_replies [$];
   logic [SET_W-1:0] sent_sets [NTMS_MAX_NODES];
   int mismatches = 0;
   logic took = 1'b0;
   bit beat_out = 1'b0;
   bit csr_out = 1'b0;
   int gap_left = 0;
   int burst_left = 1;
   int idle_cycles = 0;

   function automatic logic [SET_W-1:0] choose_relays();
      logic [SET_W-1:0] rest [NTMS_MAX_NODES];
      logic [SET_W-1:0] relays;
      logic [SET_W-1:0] cov;
      int best;
      int best_n;
      int n;
      int i;
      bit searching;
      relays = '0;
      for (i = 0; i < NTMS_MAX_NODES; i++) begin
         rest[i] = node_valid[i] ? (node_nbrs[i] & ~SET_W'(node_valid)) : '0;
      end
      searching = 1'b1;
      while (searching) begin
         best = 0;
         best_n = 0;
         // Strict compare keeps the lowest id on ties.
         for (i = 0; i < NTMS_MAX_NODES; i++) begin
            n = $countones(rest[i]);
            if (n > best_n) begin
               best_n = n;
               best = i;
            end
         end
         if (best_n == 0) begin
            searching = 1'b0;
         end else begin
            relays[best] = 1'b1;
            cov = rest[best];
            for (i = 0; i < NTMS_MAX_NODES; i++) begin
               rest[i] = rest[i] & ~cov;
            end
         end
      end
      return relays;
   endfunction

   function automatic nt_reply_type table_model_step(logic [1:0] op,
                                                     logic [NODE_ID_W-1:0] id,
                                                     logic [SET_W-1:0] nset);
      nt_reply_type r;
      int i;
      r = '0;
      case (op)
         OP_HELLO: begin
            if (!(node_valid[id] && node_nbrs[id] == nset)) begin
               node_valid[id] = 1'b1;
               node_nbrs[id] = nset;
               dirty = 1'b1;
            end
            node_heard[id] = now_sec;
         end
         OP_TICK: begin
            now_sec = now_sec + 1;
            for (i = 0; i < NTMS_MAX_NODES; i++) begin
               if (node_valid[i] && (now_sec - node_heard[i]) > TIME_W'(age_limit)) begin
                  node_valid[i] = 1'b0;
                  dirty = 1'b1;
               end
            end
         end
         OP_PICK: begin
            dirty = 1'b0;
            r.relay_set = choose_relays();
         end
         OP_QUERY: begin
            if (node_valid[id]) r.node_neighbors = node_nbrs[id];
         end
         default: ;
      endcase
      r.one_hop_set = SET_W'(node_valid);
      r.table_changed = dirty;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [SET_W-1:0] got, logic [SET_W-1:0] want);
      mismatches++;
      $display("%0t mismatch on %s: got %h expected %h", $time, what, got, want);
   endtask

   task automatic push_cmd(logic [1:0] op, logic [NODE_ID_W-1:0] id, logic [SET_W-1:0] nset);
      nt_cmd_type c;
      c = '0;
      c.kind = CMD_BEAT;
      c.op = op;
      c.node = id;
      c.nset = nset;
      cmd_queue.push_back(c);
      if (op == OP_HELLO) sent_sets[id] = nset;
   endtask

   task automatic push_age(logic [AGE_W-1:0] age);
      nt_cmd_type c;
      c = '0;
      c.kind = CMD_AGE;
      c.age = age;
      cmd_queue.push_back(c);
   endtask

   // Most ids come from a small pool so that entries get refreshed, queried and aged.
   task automatic push_random_cmd(int pool_base);
      logic [1:0] op;
      logic [NODE_ID_W-1:0] id;
      logic [SET_W-1:0] nset;
      int pick;
      int nbits;
      int k;
      pick = $urandom_range(0, 19);
      if (pick < 10) op = OP_HELLO;
      else if (pick < 13) op = OP_TICK;
      else if (pick < 16) op = OP_PICK;
      else op = OP_QUERY;
      if ($urandom_range(0, 3) == 0) id = NODE_ID_W'($urandom_range(0, NTMS_MAX_NODES - 1));
      else id = NODE_ID_W'(pool_base + $urandom_range(0, 11));
      nset = '0;
      case ($urandom_range(0, 9))
         0: nset = '0;
         1: nset = '1;
         2, 3: nset = sent_sets[id];
         4, 5, 6: begin
            nbits = $urandom_range(1, 6);
            for (k = 0; k < nbits; k++) nset[$urandom_range(0, SET_W - 1)] = 1'b1;
         end
         default: nset = {$urandom(), $urandom()};
      endcase
      push_cmd(op, id, nset);
   endtask

   // Predictor and result checker.
   always @(posedge clock) begin : sample_block
      nt_reply_type want;
      took <= !reset && start && !busy;
      if (reset) begin
         node_valid = '0;
         now_sec = '0;
         dirty = 1'b0;
         age_limit = MAX_AGE_RESET;
         expected_replies.delete();
      end else begin
         if (csr_wr_en) age_limit = csr_wr_data;
         if (rsp_strobe) begin
            if (expected_replies.size() == 0) begin
               report_mismatch("unexpected result", rsp_one_hop_set, '0);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_one_hop_set !== want.one_hop_set)
                  report_mismatch("one_hop_set", rsp_one_hop_set, want.one_hop_set);
               if (rsp_relay_set !== want.relay_set)
                  report_mismatch("relay_set", rsp_relay_set, want.relay_set);
               if (rsp_node_neighbors !== want.node_neighbors)
                  report_mismatch("node_neighbors", rsp_node_neighbors, want.node_neighbors);
               if (rsp_table_changed !== want.table_changed)
                  report_mismatch("table_changed", SET_W'(rsp_table_changed),
                                  SET_W'(want.table_changed));
            end
         end
         if (start && !busy) begin
            expected_replies.push_back(table_model_step(req_op, req_originator,
                                                        req_neighbor_set));
         end
      end
   end

   // Command driver. A register write waits until the block has drained.
   always @(negedge clock) begin : drive_block
      logic next_start;
      logic next_wr;
      next_start = 1'b0;
      next_wr = 1'b0;
      if (!reset) begin
         if (beat_out && took) begin
            cmd_queue.delete(0);
            beat_out = 1'b0;
         end
         if (csr_out) begin
            cmd_queue.delete(0);
            csr_out = 1'b0;
         end
         if (beat_out) begin
            next_start = 1'b1;
         end else if (cmd_queue.size() != 0) begin
            if (cmd_queue[0].kind == CMD_AGE) begin
               if (expected_replies.size() == 0 && !busy) begin
                  next_wr = 1'b1;
                  csr_wr_data <= cmd_queue[0].age;
                  csr_out = 1'b1;
               end
            end else if (gap_left != 0) begin
               gap_left--;
            end else begin
               next_start = 1'b1;
               req_op <= cmd_queue[0].op;
               req_originator <= cmd_queue[0].node;
               req_neighbor_set <= cmd_queue[0].nset;
               beat_out = 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
               end
            end
         end
      end
      start <= next_start;
      csr_wr_en <= next_wr;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("neighbor_table_mpr_select regression: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int p;
      int base;
      for (p = 0; p < NTMS_MAX_NODES; p++) sent_sets[p] = '0;

      // Empty table: relay pick, absent query, tick with nothing to drop.
      push_cmd(OP_PICK, 0, '0);
      push_cmd(OP_QUERY, 0, '1);
      push_cmd(OP_TICK, 0, '0);
      push_cmd(OP_HELLO, 0, '1);
      push_cmd(OP_HELLO, 63, '0);
      push_cmd(OP_HELLO, 5, 64'h1);
      // Identical set only refreshes the entry.
      push_cmd(OP_HELLO, 5, 64'h1);
      push_cmd(OP_QUERY, 0, '0);
      push_cmd(OP_QUERY, 63, '1);
      push_cmd(OP_QUERY, 12, '0);
      push_cmd(OP_PICK, 63, '1);
      push_cmd(OP_HELLO, 0, '1);
      push_cmd(OP_HELLO, 0, '0);
      // Two entries covering the same ids tie; the lower id must win.
      push_cmd(OP_HELLO, 21, 64'h3 << 40);
      push_cmd(OP_HELLO, 20, 64'h3 << 40);
      push_cmd(OP_HELLO, 22, 64'hF << 42);
      push_cmd(OP_PICK, 0, '0);
      // With the default age of three, the fourth tick drops everything.
      repeat (4) push_cmd(OP_TICK, 0, '0);
      push_cmd(OP_QUERY, 20, '0);
      push_cmd(OP_PICK, 0, '0);
      push_cmd(OP_HELLO, 63, '1);

      for (p = 0; p < 6; p++) begin
         case (p)
            0: push_age('0);
            1: push_age('1);
            2: push_age(AGE_W'(1));
            3: push_age(AGE_W'($urandom_range(0, 255)));
            4: push_age(MAX_AGE_RESET);
            default: push_age(AGE_W'(2));
         endcase
         base = $urandom_range(0, NTMS_MAX_NODES - 12);
         repeat (150) push_random_cmd(base);
      end

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (cmd_queue.size() != 0 || expected_replies.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("neighbor_table_mpr_select regression: pass");
      end else begin
         $display("neighbor_table_mpr_select regression: fail");
      end
      $finish;
   end

endmodule
